### rtl/wcct_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the window count-of-counts table.
package wcct_pkg;

  localparam int COLOUR_W    = 10;
  localparam int THRESH_W    = 11;
  localparam int ANSWER_W    = 11;
  localparam int OP_W        = 2;
  localparam int NUM_COLOURS_DEF = 1024;
  localparam int WINDOW_MAX_DEF  = 1024;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  // Work kinds that survive classification.
  typedef enum logic [1:0] {
    K_ADD,
    K_REMOVE,
    K_QUERY
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [COLOUR_W-1:0] colour;
    logic [THRESH_W-1:0] threshold;
    logic                zero_answer;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COUNT,
    ST_TABLE,
    ST_QUERY
  } st_t;

endpackage

### rtl/wcct_in_if.sv
`timescale 1ns / 1ps
// Input channel: valid/ready handshake carrying one operation item.
interface wcct_in_if;
  import wcct_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [COLOUR_W-1:0] colour;
  logic [THRESH_W-1:0] threshold;

  modport source (output valid, op, colour, threshold, input ready);
  modport sink (input valid, op, colour, threshold, output ready);
endinterface

### rtl/wcct_out_if.sv
`timescale 1ns / 1ps
// Output channel: valid/ready handshake carrying one query answer.
interface wcct_out_if;
  import wcct_pkg::*;

  logic                valid;
  logic                ready;
  logic [ANSWER_W-1:0] answer;

  modport source (output valid, answer, input ready);
  modport sink (input valid, answer, output ready);
endinterface

### rtl/wcct_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module wcct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

### rtl/wcct_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, drops unused op codes and out-of-range adds and removes, queues the rest.
module wcct_front #(
  parameter int NUM_COLOURS = wcct_pkg::NUM_COLOURS_DEF,
  parameter int WINDOW_MAX  = wcct_pkg::WINDOW_MAX_DEF
) (
  wcct_in_if.sink           items,
  input  logic              clearing,
  input  wcct_pkg::q_status_t q_status,
  output logic              push,
  output wcct_pkg::entry_t  push_data
);
  import wcct_pkg::*;

  logic colour_ok;
  logic keep;

  assign items.ready = !clearing && !q_status.full;
  assign colour_ok   = 32'(items.colour) < NUM_COLOURS;

  always_comb begin
    keep                  = 1'b0;
    push_data.kind        = K_QUERY;
    push_data.colour      = items.colour;
    push_data.threshold   = items.threshold;
    push_data.zero_answer = 32'(items.threshold) > WINDOW_MAX;
    case (op_t'(items.op))
      OP_ADD: begin
        keep           = colour_ok;
        push_data.kind = K_ADD;
      end
      OP_REMOVE: begin
        keep           = colour_ok;
        push_data.kind = K_REMOVE;
      end
      OP_QUERY: begin
        keep           = 1'b1;
        push_data.kind = K_QUERY;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = items.valid && items.ready && keep;
endmodule

### rtl/wcct_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified items between the front end and the back end.
module wcct_queue #(
  parameter int DEPTH = wcct_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wcct_pkg::entry_t    push_data,
  input  logic                pop,
  output wcct_pkg::entry_t    head,
  output wcct_pkg::q_status_t status
);
  import wcct_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  entry_t          slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  assign status.full  = count == CNTW'(DEPTH);
  assign status.empty = count == '0;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

### rtl/wcct_back.sv
`timescale 1ns / 1ps
// Back end: clearing pass, read-modify-write sequencer over both count stores, and query answers.
module wcct_back #(
  parameter int NUM_COLOURS = wcct_pkg::NUM_COLOURS_DEF,
  parameter int WINDOW_MAX  = wcct_pkg::WINDOW_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  wcct_pkg::entry_t    head,
  input  wcct_pkg::q_status_t q_status,
  output logic                pop,
  output logic                clearing,
  wcct_out_if.source          results
);
  import wcct_pkg::*;

  localparam int CIW     = $clog2(NUM_COLOURS);
  localparam int TDEPTH  = WINDOW_MAX + 1;
  localparam int TAW     = $clog2(TDEPTH);
  localparam int CW      = TAW;
  localparam int EW      = $clog2(NUM_COLOURS + 1);
  localparam int CLR_LEN = (NUM_COLOURS > TDEPTH) ? NUM_COLOURS : TDEPTH;
  localparam int CLRW    = $clog2(CLR_LEN);

  st_t                 state;
  st_t                 state_next;
  logic [CLRW-1:0]     clr_cnt;
  entry_t              cur;
  logic [TAW-1:0]      tab_addr;
  logic [TAW-1:0]      tab_addr_next;
  logic                tab_inc;
  logic                tab_inc_next;
  logic                out_valid;
  logic [ANSWER_W-1:0] answer;

  logic                cnt_wr_en;
  logic [CIW-1:0]      cnt_wr_addr;
  logic [CW-1:0]       cnt_wr_data;
  logic                cnt_rd_en;
  logic [CIW-1:0]      cnt_rd_addr;
  logic [CW-1:0]       cnt_rd_data;
  logic                tab_wr_en;
  logic [TAW-1:0]      tab_wr_addr;
  logic [EW-1:0]       tab_wr_data;
  logic                tab_rd_en;
  logic [TAW-1:0]      tab_rd_addr;
  logic [EW-1:0]       tab_rd_data;
  logic                load_out;

  logic [CIW+COLOUR_W-1:0] head_colour_ext;
  logic [CIW+COLOUR_W-1:0] cur_colour_ext;
  logic [TAW+THRESH_W-1:0] head_thr_ext;
  logic [ANSWER_W+EW-1:0]  ans_ext;
  logic                    out_free;
  logic                    clr_last;
  logic                    do_add;
  logic                    do_remove;

  assign head_colour_ext = {{CIW{1'b0}}, head.colour};
  assign cur_colour_ext  = {{CIW{1'b0}}, cur.colour};
  assign head_thr_ext    = {{TAW{1'b0}}, head.threshold};
  assign ans_ext         = {{ANSWER_W{1'b0}}, tab_rd_data};
  assign out_free        = !out_valid || results.ready;
  assign clr_last        = clr_cnt == CLRW'(CLR_LEN - 1);
  assign do_add          = (cur.kind == K_ADD) && (cnt_rd_data < CW'(WINDOW_MAX));
  assign do_remove       = (cur.kind == K_REMOVE) && (cnt_rd_data != '0);
  assign clearing        = state == ST_CLEAR;

  wcct_ram #(.WIDTH(CW), .DEPTH(NUM_COLOURS)) u_count_ram (
    .clk     (clk),
    .wr_en   (cnt_wr_en),
    .wr_addr (cnt_wr_addr),
    .wr_data (cnt_wr_data),
    .rd_en   (cnt_rd_en),
    .rd_addr (cnt_rd_addr),
    .rd_data (cnt_rd_data)
  );

  wcct_ram #(.WIDTH(EW), .DEPTH(TDEPTH)) u_table_ram (
    .clk     (clk),
    .wr_en   (tab_wr_en),
    .wr_addr (tab_wr_addr),
    .wr_data (tab_wr_data),
    .rd_en   (tab_rd_en),
    .rd_addr (tab_rd_addr),
    .rd_data (tab_rd_data)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_status.empty) begin
          if (head.kind == K_QUERY) begin
            if (out_free) begin
              state_next = ST_QUERY;
            end
          end else begin
            state_next = ST_COUNT;
          end
        end
      end
      ST_COUNT: begin
        state_next = (do_add || do_remove) ? ST_TABLE : ST_IDLE;
      end
      ST_TABLE: state_next = ST_IDLE;
      ST_QUERY: state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Memory ports and control outputs.
  always_comb begin
    pop           = 1'b0;
    cnt_wr_en     = 1'b0;
    cnt_wr_addr   = cur_colour_ext[CIW-1:0];
    cnt_wr_data   = '0;
    cnt_rd_en     = 1'b0;
    cnt_rd_addr   = head_colour_ext[CIW-1:0];
    tab_wr_en     = 1'b0;
    tab_wr_addr   = tab_addr;
    tab_wr_data   = '0;
    tab_rd_en     = 1'b0;
    tab_rd_addr   = head_thr_ext[TAW-1:0];
    load_out      = 1'b0;
    tab_addr_next = tab_addr;
    tab_inc_next  = tab_inc;
    case (state)
      ST_CLEAR: begin
        cnt_wr_en   = 32'(clr_cnt) < NUM_COLOURS;
        cnt_wr_addr = clr_cnt[CIW-1:0];
        tab_wr_en   = 32'(clr_cnt) < TDEPTH;
        tab_wr_addr = clr_cnt[TAW-1:0];
      end
      ST_IDLE: begin
        if (!q_status.empty) begin
          if (head.kind == K_QUERY) begin
            pop       = out_free;
            tab_rd_en = out_free;
          end else begin
            pop       = 1'b1;
            cnt_rd_en = 1'b1;
          end
        end
      end
      ST_COUNT: begin
        if (do_add) begin
          cnt_wr_en     = 1'b1;
          cnt_wr_data   = cnt_rd_data + 1'b1;
          tab_rd_en     = 1'b1;
          tab_rd_addr   = cnt_rd_data + 1'b1;
          tab_addr_next = cnt_rd_data + 1'b1;
          tab_inc_next  = 1'b1;
        end else if (do_remove) begin
          cnt_wr_en     = 1'b1;
          cnt_wr_data   = cnt_rd_data - 1'b1;
          tab_rd_en     = 1'b1;
          tab_rd_addr   = cnt_rd_data;
          tab_addr_next = cnt_rd_data;
          tab_inc_next  = 1'b0;
        end
      end
      ST_TABLE: begin
        tab_wr_en = 1'b1;
        if (tab_inc) begin
          tab_wr_data = tab_rd_data + 1'b1;
        end else begin
          tab_wr_data = (tab_rd_data == '0) ? tab_rd_data : tab_rd_data - 1'b1;
        end
      end
      ST_QUERY: load_out = 1'b1;
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    tab_addr <= tab_addr_next;
    tab_inc  <= tab_inc_next;
    if (load_out) begin
      answer <= cur.zero_answer ? '0 : ans_ext[ANSWER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign results.valid  = out_valid;
  assign results.answer = answer;
endmodule

### rtl/window_count_of_counts_table_top.sv
`timescale 1ns / 1ps
// Top level of the window count-of-counts table.
// A query's answer is loaded into the output register once its table entry has been
// read, if that register is free. The back end steps an add or remove through its count
// read, count write and table write states (the last is skipped when the add saturates
// or the colour is absent), and a query through its table read and output load states;
// ignored items are dropped at the input. Reset: after rst falls, a clearing pass over
// every address of both stores zeroes them, with input ready held low throughout.
module window_count_of_counts_table_top #(
  parameter int NUM_COLOURS = wcct_pkg::NUM_COLOURS_DEF,
  parameter int WINDOW_MAX  = wcct_pkg::WINDOW_MAX_DEF
) (
  input logic        clk,
  input logic        rst,
  wcct_in_if.sink    items,
  wcct_out_if.source results
);
  import wcct_pkg::*;

  // The front end classifies each item as it is accepted. Unused op codes and
  // add or remove items whose colour lies outside the table change nothing, so
  // they are consumed right there and never reach the back end.
  entry_t    push_data;
  entry_t    head;
  q_status_t q_status;
  logic      push;
  logic      pop;
  logic      clearing;

  wcct_front #(
    .NUM_COLOURS (NUM_COLOURS),
    .WINDOW_MAX  (WINDOW_MAX)
  ) u_front (
    .items     (items),
    .clearing  (clearing),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // The queue lets the input keep taking items, as long as it is not full, while the back end is in the
  // middle of a read-modify-write or waits on a stalled output.
  wcct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // The back end works one item at a time: it reads the colour's count, writes
  // the new count while reading the table entry it touches, then writes that
  // entry. Queries read the table entry straight into the output register.
  wcct_back #(
    .NUM_COLOURS (NUM_COLOURS),
    .WINDOW_MAX  (WINDOW_MAX)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .clearing (clearing),
    .results  (results)
  );
endmodule

### rtl/wcct_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the window count-of-counts table and its bind.
module wcct_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [wcct_pkg::ANSWER_W-1:0] answer
);
  import wcct_pkg::*;

  // The stores are cleared after reset, so no item may be taken right away.
  a_ready_low_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input ready high in the cycle after reset");

  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid in the cycle after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(answer))
    else $error("stalled result changed or vanished");
endmodule

bind window_count_of_counts_table_top wcct_checker u_wcct_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (items.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .answer    (results.answer)
);

### tb/window_count_of_counts_table_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the window count-of-counts table: directed and random items.
module window_count_of_counts_table_top_test;
  import wcct_pkg::*;

  // The block is built with its default sizes, and the tracking model below uses the same.
  localparam int NUM_COLOURS = NUM_COLOURS_DEF;
  localparam int WINDOW_MAX  = WINDOW_MAX_DEF;

  // The op field has one code that the block does not define; it must be dropped.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Number of colours, spread evenly over the whole range, in the palette test.
  localparam int PALETTE_SPAN = 32;

  // The clearing pass after reset comes first. The slowest correct run has some 1350
  // items, each waiting out the back end, sender gaps and receiver stalls of up to 62
  // percent. This limit leaves a wide margin over that run.
  localparam int LIMIT_CYCLES = 400000;

  // Cycles to wait after the last answer has been checked.
  localparam int TAIL_CYCLES = 12;

  logic clk;
  logic rst;

  wcct_in_if  in_ch ();
  wcct_out_if out_ch ();

  window_count_of_counts_table_top u_top (
    .clk    (clk),
    .rst    (rst),
    .items  (in_ch),
    .results(out_ch)
  );

  // Tracking model of the window: the occurrence count of every colour, and the table
  // whose entry k holds how many colours occur at least k times.
  logic [THRESH_W-1:0] colour_tally [0:NUM_COLOURS-1];
  logic [ANSWER_W-1:0] reach_table [0:WINDOW_MAX];

  // Answers that queries already accepted by the block are owed, oldest first.
  logic [ANSWER_W-1:0] pending_answers [$];

  int errors = 0;
  int cycle_count = 0;

  // Percent of cycles in which the sender holds valid low and the receiver holds
  // ready low. The main sequence changes these between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // 10 ns clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Empties both stores of the tracking model, matching the state after reset.
  function automatic void clear_window_model();
    for (int i = 0; i < NUM_COLOURS; i++) colour_tally[i] = '0;
    for (int k = 0; k <= WINDOW_MAX; k++) reach_table[k] = '0;
  endfunction

  // Applies one accepted item to the tracking model. A query owes one answer; adds and
  // removes only move the counts, and every ignored case leaves the model alone.
  function automatic void track_item(logic [OP_W-1:0] op, logic [COLOUR_W-1:0] colour,
                                     logic [THRESH_W-1:0] threshold);
    int cnt;
    cnt = colour_tally[colour];
    case (op)
      OP_QUERY: begin
        // Thresholds past the window capacity have no table entry; nobody reaches them.
        if (threshold <= WINDOW_MAX) pending_answers.push_back(reach_table[threshold]);
        else pending_answers.push_back('0);
      end
      OP_ADD: begin
        // A colour already at capacity saturates and the add is dropped.
        if (cnt < WINDOW_MAX) begin
          cnt = cnt + 1;
          colour_tally[colour] = cnt;
          reach_table[cnt] = reach_table[cnt] + 1'b1;
        end
      end
      OP_REMOVE: begin
        // Removing an absent colour is dropped. The table entry never goes below zero.
        if (cnt > 0) begin
          if (reach_table[cnt] != '0) reach_table[cnt] = reach_table[cnt] - 1'b1;
          colour_tally[colour] = cnt - 1;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Offers one item to the block and returns right after the clock edge that accepts it.
  // Valid is never lowered and raised in one time step: when no gap is drawn, the item
  // follows the previous one back to back with valid held high.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [COLOUR_W-1:0] colour,
                           input logic [THRESH_W-1:0] threshold);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.colour    <= colour;
    in_ch.threshold <= threshold;
    do @(posedge clk); while (!in_ch.ready);
    track_item(op, colour, threshold);
  endtask

  // Answer checker. It samples the handshake right after each rising edge, before the
  // block's registers move, and draws the receiver's ready for the next cycle.
  initial begin : answer_checker
    logic [ANSWER_W-1:0] want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        if (pending_answers.size() == 0) begin
          errors++;
          $error("answer: no query waiting, actual %0d", out_ch.answer);
        end else begin
          want = pending_answers.pop_front();
          if (out_ch.answer !== want) begin
            errors++;
            $error("answer: expected %0d, actual %0d", want, out_ch.answer);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Field extremes and the special cases: query at threshold zero and past the window
  // capacity, removing an absent colour, the unused op code, and the colour field of a
  // query being ignored.
  task automatic test_directed_edges();
    send_item(OP_QUERY, 10'd0, 11'd0);
    send_item(OP_ADD, 10'd0, 11'd0);
    send_item(OP_ADD, 10'd1023, 11'd2047);
    send_item(OP_ADD, 10'd1023, 11'd0);
    send_item(OP_QUERY, 10'd1023, 11'd1);
    send_item(OP_QUERY, 10'd0, 11'd2);
    send_item(OP_QUERY, 10'd0, 11'd3);
    send_item(OP_QUERY, 10'd0, 11'd1024);
    send_item(OP_QUERY, 10'd0, 11'd1025);
    send_item(OP_QUERY, 10'd1023, 11'd2047);
    send_item(OP_REMOVE, 10'd512, 11'd0);
    send_item(OP_UNUSED, 10'd1023, 11'd2047);
    send_item(OP_UNUSED, 10'd0, 11'd0);
    send_item(OP_QUERY, 10'd1023, 11'd0);
    send_item(OP_REMOVE, 10'd1023, 11'd0);
    send_item(OP_QUERY, 10'd0, 11'd2);
    send_item(OP_REMOVE, 10'd1023, 11'd0);
    send_item(OP_REMOVE, 10'd1023, 11'd0);
    send_item(OP_REMOVE, 10'd0, 11'd0);
    send_item(OP_QUERY, 10'd0, 11'd1);
    send_item(OP_ADD, 10'h2AA, 11'h555);
    send_item(OP_ADD, 10'h155, 11'h2AA);
    send_item(OP_QUERY, 10'h3FF, 11'h555);
    send_item(OP_QUERY, 10'h000, 11'h2AA);
    send_item(OP_QUERY, 10'h2AA, 11'd1);
  endtask

  // One colour is driven up to the window capacity and past it, so the add saturates,
  // then a few removes walk it back down from the top of the table.
  task automatic test_saturation();
    for (int i = 0; i < WINDOW_MAX + 2; i++) begin
      send_item(OP_ADD, 10'h0F0, 11'd0);
      if (i >= WINDOW_MAX - 2) send_item(OP_QUERY, 10'd0, 11'(WINDOW_MAX));
    end
    send_item(OP_QUERY, 10'd0, 11'(WINDOW_MAX - 1));
    for (int i = 0; i < 6; i++) send_item(OP_REMOVE, 10'h0F0, 11'd0);
    send_item(OP_QUERY, 10'd0, 11'(WINDOW_MAX));
    send_item(OP_QUERY, 10'd0, 11'(WINDOW_MAX - 6));
  endtask

  // Colours spread over the whole range enter the window once each, then leave once.
  task automatic test_full_palette();
    for (int c = 0; c < PALETTE_SPAN; c++) begin
      send_item(OP_ADD, 10'(c * (NUM_COLOURS / PALETTE_SPAN)), 11'd0);
    end
    send_item(OP_QUERY, 10'd0, 11'd1);
    send_item(OP_QUERY, 10'd0, 11'd2);
    for (int c = 0; c < PALETTE_SPAN; c++) begin
      send_item(OP_REMOVE, 10'(c * (NUM_COLOURS / PALETTE_SPAN)), 11'd0);
    end
    send_item(OP_QUERY, 10'd0, 11'd1);
  endtask

  // Random window traffic. Most items add and remove colours from a small pool, so the
  // counts climb and queries land on populated thresholds. The rest is noise: colours
  // from the whole range, removes of absent colours, wide thresholds and the unused
  // op code. Items of the unused code are not counted toward the total.
  task automatic test_random_window(input int n_items);
    int done;
    int r;
    int pool_size;
    logic [COLOUR_W-1:0] pool_base;
    logic [COLOUR_W-1:0] colour;
    logic [THRESH_W-1:0] threshold;
    done = 0;
    pool_base = COLOUR_W'($urandom);
    pool_size = $urandom_range(1, 16);
    while (done < n_items) begin
      if ($urandom_range(99) < 2) begin
        pool_base = COLOUR_W'($urandom);
        pool_size = $urandom_range(1, 16);
      end
      colour = pool_base + COLOUR_W'($urandom_range(0, pool_size - 1));
      if ($urandom_range(99) < 6) colour = COLOUR_W'($urandom);
      if ($urandom_range(99) < 85) threshold = THRESH_W'($urandom_range(0, 24));
      else threshold = THRESH_W'($urandom_range(0, 2047));
      r = $urandom_range(99);
      if (r < 42) begin
        send_item(OP_ADD, colour, THRESH_W'($urandom));
        done++;
      end else if (r < 64) begin
        send_item(OP_REMOVE, colour, THRESH_W'($urandom));
        done++;
      end else if (r < 95) begin
        send_item(OP_QUERY, COLOUR_W'($urandom), threshold);
        done++;
      end else begin
        send_item(OP_UNUSED, COLOUR_W'($urandom), THRESH_W'($urandom));
      end
    end
  endtask

  // Main sequence. Reset is asserted first; the block then runs its clearing
  // pass with ready low, which the first send simply waits out.
  initial begin
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= OP_ADD;
    in_ch.colour    <= '0;
    in_ch.threshold <= '0;
    clear_window_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Phase one: a lightly idling sender against a receiver that stalls often.
    send_idle_pct = 14;
    recv_idle_pct = 62;
    test_directed_edges();
    test_saturation();
    test_random_window(70);

    // Phase two: the sender idles often and the receiver rarely.
    send_idle_pct = 62;
    recv_idle_pct = 14;
    test_full_palette();
    test_random_window(70);

    // Phase three: no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_window(70);

    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### window_count_of_counts_table_top.f
rtl/wcct_pkg.sv
rtl/wcct_in_if.sv
rtl/wcct_out_if.sv
rtl/wcct_ram.sv
rtl/wcct_front.sv
rtl/wcct_queue.sv
rtl/wcct_back.sv
rtl/window_count_of_counts_table_top.sv
rtl/wcct_checker.sv
tb/window_count_of_counts_table_top_test.sv
